@@ sv/ima_pkg.sv @@
// ============================================================================
// ima_pkg
// Shared types, constants and codes of the integer matrix ALU.
// ============================================================================
package ima_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int WIDTH_DEF   = 32;
    localparam int ELEM_W      = 32;
    localparam int CNT_W       = 4;
    localparam int MODE_W      = 3;
    localparam int IDX_W       = 3;

    localparam logic [MODE_W-1:0] OP_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] OP_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] OP_MUL  = 3'd2;
    localparam logic [MODE_W-1:0] OP_SCL  = 3'd3;
    localparam logic [MODE_W-1:0] OP_DIV  = 3'd4;
    localparam logic [MODE_W-1:0] OP_TRN  = 3'd5;
    localparam logic [MODE_W-1:0] OP_CMP  = 3'd6;

    localparam logic [IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROWS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_INNER   = 3'd2;
    localparam logic [IDX_W-1:0] REG_COLS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALAR  = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_EMIT,
        ST_WAIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write incoming element into a store
        logic start;      // clear indices, load counters and accumulator
        logic issue;      // present read addresses for current index
        logic exec;       // consume read data
        logic div_start;  // launch divider
        logic push;       // place result into output register
        logic advance;    // step indices
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic mac_more;   // multiply: more inner steps remain
        logic need_div;   // divide mode with nonzero divisor
        logic div_done;
        logic emit_now;   // this element produces an output
        logic run_done;   // last element processed
        logic no_output;  // mode emits nothing
        logic out_free;   // output register can take a value
    } stat_t;

endpackage

@@ sv/ima_ram.sv @@
// ============================================================================
// ima_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module ima_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/ima_div.sv @@
// ============================================================================
// ima_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ============================================================================
module ima_div #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] abs_a;
    logic [WIDTH-1:0] abs_b;

    assign abs_a = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign abs_b = divisor[WIDTH-1]  ? (~divisor + 1'b1)  : divisor;
    assign trial = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = abs_a;
            den_next  = abs_b;
            neg_next  = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

@@ sv/ima_ctrl.sv @@
// ============================================================================
// ima_ctrl
// Run sequencer: load, read, execute, optional divide, emit, wait for output.
// ============================================================================
module ima_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             in_final,
    input  ima_pkg::stat_t   stat,
    output ima_pkg::ctrl_t   ctrl,
    output logic             in_ready
);

    ima_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ima_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ima_pkg::ST_LOAD:
            begin
                if (in_fire && in_final)
                begin
                    state_next = ima_pkg::ST_READ;
                end
            end
            ima_pkg::ST_READ:
            begin
                if (stat.no_output)
                begin
                    state_next = ima_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = ima_pkg::ST_EXEC;
                end
            end
            ima_pkg::ST_EXEC:
            begin
                priority if (stat.mac_more)
                begin
                    state_next = ima_pkg::ST_READ;
                end
                else if (stat.need_div)
                begin
                    state_next = ima_pkg::ST_DIV;
                end
                else
                begin
                    state_next = ima_pkg::ST_EMIT;
                end
            end
            ima_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ima_pkg::ST_EMIT;
                end
            end
            ima_pkg::ST_EMIT:
            begin
                if (!stat.emit_now || stat.out_free)
                begin
                    state_next = stat.run_done ? ima_pkg::ST_WAIT : ima_pkg::ST_READ;
                end
            end
            ima_pkg::ST_WAIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ima_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = ima_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ima_pkg::ST_LOAD:
            begin
                in_ready   = 1'b1;
                ctrl.load  = in_fire;
                ctrl.start = in_fire && in_final;
            end
            ima_pkg::ST_READ:
            begin
                ctrl.issue = 1'b1;
            end
            ima_pkg::ST_EXEC:
            begin
                ctrl.exec      = 1'b1;
                ctrl.div_start = !stat.mac_more && stat.need_div;
            end
            ima_pkg::ST_DIV:
            begin
            end
            ima_pkg::ST_EMIT:
            begin
                if (!stat.emit_now || stat.out_free)
                begin
                    ctrl.push    = stat.emit_now;
                    ctrl.advance = 1'b1;
                end
            end
            ima_pkg::ST_WAIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ sv/ima_dp.sv @@
// ============================================================================
// ima_dp
// Stores, index counters, MAC/ALU, divider and output register.
// ============================================================================
module ima_dp #(
    parameter int MAX_DIM = ima_pkg::MAX_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ima_pkg::ctrl_t              ctrl,
    output ima_pkg::stat_t              stat,
    input  logic [ima_pkg::ELEM_W-1:0]  element_value,
    input  logic                        to_second,
    input  logic                        cfg_we,
    input  logic [ima_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ima_pkg::ELEM_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ima_pkg::ELEM_W-1:0]  out_value,
    output logic                        out_last,
    output logic                        out_err
);

    localparam int WIDTH = ima_pkg::WIDTH_DEF;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM);
    localparam int EW    = ima_pkg::ELEM_W;
    localparam int CW    = ima_pkg::CNT_W;

    logic [ima_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]              rows_reg, inner_reg, cols_reg;
    logic [EW-1:0]              scalar_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ima_pkg::OP_ADD;
            rows_reg   <= CW'(8);
            inner_reg  <= CW'(8);
            cols_reg   <= CW'(8);
            scalar_reg <= EW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ima_pkg::REG_OP_MODE: mode_reg   <= cfg_data[ima_pkg::MODE_W-1:0];
                ima_pkg::REG_ROWS:    rows_reg   <= cfg_data[CW-1:0];
                ima_pkg::REG_INNER:   inner_reg  <= cfg_data[CW-1:0];
                ima_pkg::REG_COLS:    cols_reg   <= cfg_data[CW-1:0];
                ima_pkg::REG_SCALAR:  scalar_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [DW:0] clampd(input logic [CW-1:0] v);
        logic [DW:0] r;
        if (v == '0)
        begin
            r = (DW+1)'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = (DW+1)'(MAX_DIM);
        end
        else
        begin
            r = v[DW:0];
        end
        return r;
    endfunction

    logic [DW:0] nr, nk, nc;
    assign nr = clampd(rows_reg);
    assign nk = clampd(inner_reg);
    assign nc = clampd(cols_reg);

    // element narrowed to WIDTH then sign extended back (wrap of the store)
    function automatic logic [EW-1:0] wrap_e(input logic [EW-1:0] v);
        logic [63:0] x;
        x = {{(64-EW){v[EW-1]}}, v};
        x = 64'($signed(x[WIDTH-1:0]));
        return x[EW-1:0];
    endfunction

    // load side
    logic [LW-1:0] li1_reg, li2_reg;
    logic          we1, we2;

    assign we1 = ctrl.load && !to_second && (32'(li1_reg) < DEPTH);
    assign we2 = ctrl.load &&  to_second && (32'(li2_reg) < DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            li1_reg <= '0;
            li2_reg <= '0;
        end
        else if (ctrl.start)
        begin
            li1_reg <= '0;
            li2_reg <= '0;
        end
        else
        begin
            if (we1) li1_reg <= li1_reg + 1'b1;
            if (we2) li2_reg <= li2_reg + 1'b1;
        end
    end

    // run indices
    logic [DW:0] r_reg, c_reg, k_reg;
    logic        cmp_same_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] res_reg;
    logic        err_reg;

    logic [AW-1:0] addr_a, addr_b;
    logic        is_mul, is_trn, is_cmp;

    assign is_mul = (mode_reg == ima_pkg::OP_MUL);
    assign is_trn = (mode_reg == ima_pkg::OP_TRN);
    assign is_cmp = (mode_reg == ima_pkg::OP_CMP);

    always_comb
    begin
        addr_a = AW'(32'(r_reg) * 32'(nc) + 32'(c_reg));
        addr_b = addr_a;
        if (is_mul)
        begin
            addr_a = AW'(32'(r_reg) * 32'(nk) + 32'(k_reg));
            addr_b = AW'(32'(k_reg) * 32'(nc) + 32'(c_reg));
        end
        else if (is_trn)
        begin
            // r_reg walks output rows (source columns), c_reg output cols
            addr_a = AW'(32'(c_reg) * 32'(nc) + 32'(r_reg));
        end
    end

    logic [EW-1:0] qa, qb;

    ima_ram #(.DATA_W(EW), .DEPTH(DEPTH)) u_ram_a (
        .clk(clk), .we(we1), .waddr(li1_reg[AW-1:0]), .wdata(wrap_e(element_value)),
        .raddr(addr_a), .rdata(qa)
    );
    ima_ram #(.DATA_W(EW), .DEPTH(DEPTH)) u_ram_b (
        .clk(clk), .we(we2), .waddr(li2_reg[AW-1:0]), .wdata(wrap_e(element_value)),
        .raddr(addr_b), .rdata(qb)
    );

    logic [WIDTH-1:0] a_w, b_w, s_w;
    assign a_w = qa[WIDTH-1:0];
    assign b_w = qb[WIDTH-1:0];
    assign s_w = scalar_reg[WIDTH-1:0];

    logic [DW:0] maj_lim, min_lim;
    assign maj_lim = is_trn ? nc : nr;
    assign min_lim = is_trn ? nr : nc;

    logic last_k, last_min, last_maj, last_elem;
    assign last_k    = (k_reg == nk - 1'b1);
    assign last_min  = (c_reg == min_lim - 1'b1);
    assign last_maj  = (r_reg == maj_lim - 1'b1);
    assign last_elem = last_min && last_maj;

    logic [WIDTH-1:0] prod;
    logic [WIDTH-1:0] alu;
    logic             div_zero;
    assign div_zero = (s_w == '0);

    always_comb
    begin
        prod = a_w * (is_mul ? b_w : s_w);
        unique case (mode_reg)
            ima_pkg::OP_ADD: alu = a_w + b_w;
            ima_pkg::OP_SUB: alu = a_w - b_w;
            ima_pkg::OP_MUL: alu = acc_reg + prod;
            ima_pkg::OP_SCL: alu = prod;
            ima_pkg::OP_TRN: alu = a_w;
            default:         alu = '0;
        endcase
    end

    logic             div_done;
    logic [WIDTH-1:0] div_q;

    ima_div #(.WIDTH(WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .start(ctrl.div_start),
        .dividend(a_w), .divisor(s_w), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            cmp_same_reg <= 1'b1;
        end
        else if (ctrl.start)
        begin
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            cmp_same_reg <= 1'b1;
        end
        else
        begin
            if (ctrl.exec)
            begin
                if (is_cmp && (a_w != b_w))
                begin
                    cmp_same_reg <= 1'b0;
                end
                if (is_mul && !last_k)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (ctrl.advance)
            begin
                k_reg <= '0;
                if (last_min)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            acc_reg <= alu;
            err_reg <= (mode_reg == ima_pkg::OP_DIV) && div_zero;
            if (mode_reg == ima_pkg::OP_DIV)
            begin
                res_reg <= '0;
            end
            else if (is_cmp)
            begin
                res_reg <= WIDTH'((cmp_same_reg && (a_w == b_w)) ? 1 : 0);
            end
            else
            begin
                res_reg <= alu;
            end
        end
        else if (div_done)
        begin
            res_reg <= div_q;
        end
        if (ctrl.advance)
        begin
            acc_reg <= '0;
        end
    end

    // output register
    logic          ov_reg;
    logic [EW-1:0] ovl_reg;
    logic          olast_reg, oerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            ovl_reg   <= EW'($signed(res_reg));
            olast_reg <= last_elem;
            oerr_reg  <= err_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_value = ovl_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;

    assign stat.mac_more  = is_mul && !last_k;
    assign stat.need_div  = (mode_reg == ima_pkg::OP_DIV) && !div_zero;
    assign stat.div_done  = div_done;
    assign stat.emit_now  = !is_cmp || last_elem;
    assign stat.run_done  = last_elem;
    assign stat.no_output = (mode_reg > ima_pkg::OP_CMP);
    assign stat.out_free  = !ov_reg || out_ready;

endmodule

@@ sv/integer_matrix_alu_unit.sv @@
// ============================================================================
// integer_matrix_alu_unit
// Loads two signed matrices, then runs add/sub/mul/scale/div/transpose/compare.
// ============================================================================
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tdata element, tuser to_second, tlast final
//  m_axis    | out       | m_axis_tvalid/tready    | tdata result, tuser divide_error, tlast last
//  cfg       | in        | cfg_we                  | cfg_index, cfg_data
//
//  Loads accept one element per cycle. A run reads the stores once per step: each
//  output element passes read, execute and emit, multiply repeats read and execute
//  per inner step, and divide waits in the bit-serial divider before emit. Compare
//  walks all R*C pairs and emits one item. No input transaction is taken while a
//  run is in flight; a held result with m_axis_tready low stalls the sequencer at
//  the next emit. Reset clears control state and the config registers only.
// ============================================================================
module integer_matrix_alu_unit #(
    parameter int MAX_DIM = ima_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element_value
    input  logic        s_axis_tuser,   // [0] to_second
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic        m_axis_tuser,   // [0] divide_error
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ima_pkg::ctrl_t ctrl;
    ima_pkg::stat_t stat;
    logic           in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // sequencer
    ima_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_final(s_axis_tlast),
        .stat(stat), .ctrl(ctrl), .in_ready(s_axis_tready)
    );

    // stores, arithmetic and output register
    ima_dp #(.MAX_DIM(MAX_DIM)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .element_value(s_axis_tdata), .to_second(s_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(m_axis_tdata), .out_last(m_axis_tlast), .out_err(m_axis_tuser)
    );

endmodule

@@ sv/ima_checker.sv @@
// ============================================================================
// ima_checker
// Port-level checks of the integer matrix ALU.
// ============================================================================
module ima_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the final load closes input until the run ends
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open during run");

    // no results appear while loading
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && $past(s_axis_tready) |-> !$rose(m_axis_tvalid))
        else $error("result during load");

    // the last result reopens input only after it is taken
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tready |-> !s_axis_tready)
        else $error("input reopened before last result");

endmodule

bind integer_matrix_alu_unit ima_checker u_ima_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
